// ===== hw/rtl/qel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qel_pkg
// Shared types, character codes and keyword helpers for the query lexer.
// ----------------------------------------------------------------------------
package qel_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_STR  = 3'd2,
    MODE_BT   = 3'd3,
    MODE_BTQ  = 3'd4,
    MODE_LT   = 3'd5,
    MODE_GT   = 3'd6
  } mode_t;

  typedef enum logic [4:0] {
    KIND_INVALID = 5'd0,
    KIND_INTERP  = 5'd1,
    KIND_STRING  = 5'd2,
    KIND_LPAREN  = 5'd3,
    KIND_LBRACK  = 5'd4,
    KIND_RBRACK  = 5'd5,
    KIND_COMMA   = 5'd6,
    KIND_RPAREN  = 5'd7,
    KIND_LTE     = 5'd8,
    KIND_LT      = 5'd9,
    KIND_GTE     = 5'd10,
    KIND_GT      = 5'd11,
    KIND_EQ      = 5'd12,
    KIND_IDENT   = 5'd13,
    KIND_IS      = 5'd14,
    KIND_AND     = 5'd15,
    KIND_OR      = 5'd16,
    KIND_NOT     = 5'd17,
    KIND_HAS     = 5'd18,
    KIND_IN      = 5'd19,
    KIND_IF      = 5'd20,
    KIND_THEN    = 5'd21,
    KIND_ELSE    = 5'd22,
    KIND_END     = 5'd23
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic        last;
  } token_t;

  // Up to two tokens per character word, written into the result queue.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } lex_push_t;

  localparam logic [15:0] CH_BACKTICK = 16'h0060;
  localparam logic [15:0] CH_DOLLAR   = 16'h0024;
  localparam logic [15:0] CH_DQUOTE   = 16'h0022;
  localparam logic [15:0] CH_SQUOTE   = 16'h0027;
  localparam logic [15:0] CH_LBRACE   = 16'h007B;
  localparam logic [15:0] CH_RBRACE   = 16'h007D;
  localparam logic [15:0] CH_LPAREN   = 16'h0028;
  localparam logic [15:0] CH_RPAREN   = 16'h0029;
  localparam logic [15:0] CH_LBRACK   = 16'h005B;
  localparam logic [15:0] CH_RBRACK   = 16'h005D;
  localparam logic [15:0] CH_COMMA    = 16'h002C;
  localparam logic [15:0] CH_LESS     = 16'h003C;
  localparam logic [15:0] CH_GREATER  = 16'h003E;
  localparam logic [15:0] CH_EQUAL    = 16'h003D;

  localparam logic [31:0] KW_IS   = "IS";
  localparam logic [31:0] KW_AND  = "AND";
  localparam logic [31:0] KW_OR   = "OR";
  localparam logic [31:0] KW_NOT  = "NOT";
  localparam logic [31:0] KW_HAS  = "HAS";
  localparam logic [31:0] KW_IN   = "IN";
  localparam logic [31:0] KW_IF   = "IF";
  localparam logic [31:0] KW_THEN = "THEN";
  localparam logic [31:0] KW_ELSE = "ELSE";

  function automatic logic is_space(input logic [15:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 ||
           c == 16'h0085 || c == 16'h00A0;
  endfunction

  function automatic logic is_boundary(input logic [15:0] c);
    return c == CH_LESS || c == CH_GREATER || c == CH_EQUAL ||
           c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK ||
           c == CH_RBRACK || c == CH_COMMA;
  endfunction

  // Upper-case ASCII letters; anything outside ASCII folds to zero.
  function automatic logic [7:0] fold_char(input logic [15:0] c);
    logic [7:0] b;
    b = 8'h00;
    if (c < 16'h0080) begin
      b = c[7:0];
      if (b >= 8'h61 && b <= 8'h7A) begin
        b = b - 8'd32;
      end
    end
    return b;
  endfunction

  function automatic kind_t word_kind(input logic [31:0] prefix, input logic [2:0] len);
    kind_t k;
    k = KIND_IDENT;
    priority if (len == 3'd2 && prefix == KW_IS) k = KIND_IS;
    else if (len == 3'd3 && prefix == KW_AND)    k = KIND_AND;
    else if (len == 3'd2 && prefix == KW_OR)     k = KIND_OR;
    else if (len == 3'd3 && prefix == KW_NOT)    k = KIND_NOT;
    else if (len == 3'd3 && prefix == KW_HAS)    k = KIND_HAS;
    else if (len == 3'd2 && prefix == KW_IN)     k = KIND_IN;
    else if (len == 3'd2 && prefix == KW_IF)     k = KIND_IF;
    else if (len == 3'd4 && prefix == KW_THEN)   k = KIND_THEN;
    else if (len == 3'd4 && prefix == KW_ELSE)   k = KIND_ELSE;
    else                                         k = KIND_IDENT;
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/query_expression_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// query_expression_lexer
// Streaming lexer for query expressions, one UTF-16 code unit per word.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character word per handshake; in_end_of_text = 1 closes the
//           text (in_character is then ignored), flushes any open token and
//           emits End; the lexer then starts a fresh text at position 0.
//   out_* : one token word per handshake, kind plus start and end positions;
//           out_last_of_item marks the last token caused by an input word.
// Path: a character taken on in_* waits in the input register; the lexer
//   step then writes its tokens into the token queue, whose head drives out_*.
// Throughput: one character per cycle while the token queue has room; the
//   step is a single pass of mode update and compares. The output side gives
//   one token per cycle while out_ready is high; a two-token word leaves as two.
// Stall: a four-entry token queue sits between lexer and output. The input
//   register steps only while the queue has room for two tokens, so an
//   output stall backs up into in_ready once the queue holds more than two tokens.
// Reset: synchronous, active low; clears the lexer to idle at position 0 and
//   empties the queue. in_ready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module query_expression_lexer #(
  parameter int unsigned MAX_TEXT_LEN     = 65535,
  parameter int unsigned MAX_INTERP_DEPTH = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_character,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_start_pos,
  output logic [15:0]      out_end_pos,
  output logic             out_last_of_item
);
  import qel_pkg::*;

  // Input register: holds one character word until the lexer steps on it.
  logic        in_vld_r;
  logic [15:0] in_char_r;
  logic        in_eot_r;
  logic        step_en;
  logic        room;
  lex_push_t   push;
  token_t      head;

  // Step when a word is held and the queue can take both possible tokens.
  assign step_en  = in_vld_r && room;
  // Take a new word when the register is empty or is draining this cycle.
  assign in_ready = !in_vld_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  // Payload needs no reset; load it with each accepted word.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_character;
      in_eot_r  <= in_end_of_text;
    end
  end

  qel_lex #(
    .MAX_TEXT_LEN     (MAX_TEXT_LEN),
    .MAX_INTERP_DEPTH (MAX_INTERP_DEPTH)
  ) u_lex (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .char_i  (in_char_r),
    .eot_i   (in_eot_r),
    .push_o  (push)
  );

  qel_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .head_o      (head)
  );

  // Drive the result word straight from the queue head.
  assign out_token_kind   = head.kind;
  assign out_start_pos    = head.start_pos;
  assign out_end_pos      = head.end_pos;
  assign out_last_of_item = head.last;

`ifndef SYNTHESIS
  a_step_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |-> in_vld_r)
    else $error("tokens pushed without a held word");
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !step_en) |=> (in_vld_r && $stable(in_char_r) && $stable(in_eot_r)))
    else $error("held word lost while queue full");
  a_eot_pushes_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && in_eot_r) |-> push.count != 2'd0)
    else $error("end of text produced no token");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/qel_lex.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qel_lex
// Lexer state and the single-pass step that turns one character word into
// zero, one or two tokens.
// ----------------------------------------------------------------------------
module qel_lex #(
  parameter int unsigned MAX_TEXT_LEN     = 65535,
  parameter int unsigned MAX_INTERP_DEPTH = 255
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic [15:0]       char_i,
  input  wire logic              eot_i,
  output qel_pkg::lex_push_t     push_o
);
  import qel_pkg::*;

  localparam int unsigned DEPTH_W = $clog2(MAX_INTERP_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_INTERP_DEPTH);
  localparam logic [15:0] POS_CAP =
    (MAX_TEXT_LEN < 32'd65535) ? 16'(MAX_TEXT_LEN) : 16'hFFFF;

  mode_t              mode_r, mode_nxt;
  logic               quote_r, quote_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               dollar_r, dollar_nxt;
  logic [15:0]        tok_start_r, tok_start_nxt;
  logic [15:0]        pos_r, pos_nxt;
  logic [31:0]        prefix_r, prefix_nxt;
  logic [2:0]         len_r, len_nxt;

  // Start-of-token decode for a character seen outside any token.
  logic        si_space;
  logic        si_emit;
  kind_t       si_kind;
  mode_t       si_mode;
  logic        si_quote;
  logic [7:0]  fold_b;
  logic [15:0] pos_p1;
  logic        do_start;
  logic [1:0]  n;
  token_t      tok0, tok1;

  assign si_space = is_space(char_i);
  assign fold_b   = fold_char(char_i);
  assign pos_p1   = pos_r + 16'd1;

  always_comb begin
    si_emit  = 1'b0;
    si_kind  = KIND_IDENT;
    si_mode  = MODE_IDLE;
    si_quote = quote_r;
    unique case (char_i)
      CH_BACKTICK: si_mode = MODE_BT;
      CH_DQUOTE: begin
        si_mode  = MODE_STR;
        si_quote = 1'b0;
      end
      CH_SQUOTE: begin
        si_mode  = MODE_STR;
        si_quote = 1'b1;
      end
      CH_LPAREN: begin
        si_emit = 1'b1;
        si_kind = KIND_LPAREN;
      end
      CH_LBRACK: begin
        si_emit = 1'b1;
        si_kind = KIND_LBRACK;
      end
      CH_RBRACK: begin
        si_emit = 1'b1;
        si_kind = KIND_RBRACK;
      end
      CH_COMMA: begin
        si_emit = 1'b1;
        si_kind = KIND_COMMA;
      end
      CH_RPAREN: begin
        si_emit = 1'b1;
        si_kind = KIND_RPAREN;
      end
      CH_EQUAL: begin
        si_emit = 1'b1;
        si_kind = KIND_EQ;
      end
      CH_LESS:    si_mode = MODE_LT;
      CH_GREATER: si_mode = MODE_GT;
      default:    si_mode = MODE_WORD;
    endcase
  end

  always_comb begin
    mode_nxt      = mode_r;
    quote_nxt     = quote_r;
    depth_nxt     = depth_r;
    dollar_nxt    = dollar_r;
    tok_start_nxt = tok_start_r;
    pos_nxt       = pos_r;
    prefix_nxt    = prefix_r;
    len_nxt       = len_r;
    do_start      = 1'b0;
    n             = 2'd0;
    tok0          = '{kind: KIND_INVALID, start_pos: tok_start_r, end_pos: pos_r, last: 1'b0};
    tok1          = '{kind: KIND_END, start_pos: pos_r, end_pos: pos_r, last: 1'b1};

    if (eot_i) begin
      // Flush a pending token, then emit End and restart.
      unique case (mode_r)
        MODE_WORD: begin
          tok0.kind = word_kind(prefix_r, len_r);
          n = 2'd1;
        end
        MODE_LT: begin
          tok0.kind = KIND_LT;
          n = 2'd1;
        end
        MODE_GT: begin
          tok0.kind = KIND_GT;
          n = 2'd1;
        end
        MODE_STR, MODE_BT, MODE_BTQ: begin
          tok0.kind = KIND_INVALID;
          n = 2'd1;
        end
        default: n = 2'd0;
      endcase
      if (n == 2'd0) begin
        tok0 = tok1;
      end
      n             = n + 2'd1;
      mode_nxt      = MODE_IDLE;
      quote_nxt     = 1'b0;
      depth_nxt     = '0;
      dollar_nxt    = 1'b0;
      tok_start_nxt = 16'd0;
      pos_nxt       = 16'd0;
      prefix_nxt    = 32'd0;
      len_nxt       = 3'd0;
    end else begin
      if (pos_r < POS_CAP) begin
        pos_nxt = pos_p1;
      end
      unique case (mode_r)
        MODE_WORD: begin
          if (si_space || is_boundary(char_i)) begin
            tok0.kind = word_kind(prefix_r, len_r);
            n         = 2'd1;
            mode_nxt  = MODE_IDLE;
            do_start  = 1'b1;
          end else begin
            if (len_r < 3'd4) prefix_nxt = {prefix_r[23:0], fold_b};
            if (len_r < 3'd5) len_nxt = len_r + 3'd1;
          end
        end
        MODE_STR: begin
          if (char_i == (quote_r ? CH_SQUOTE : CH_DQUOTE)) begin
            tok0.kind    = KIND_STRING;
            tok0.end_pos = pos_p1;
            n            = 2'd1;
            mode_nxt     = MODE_IDLE;
          end
        end
        MODE_BTQ: begin
          if (char_i == (quote_r ? CH_SQUOTE : CH_DQUOTE)) begin
            mode_nxt = MODE_BT;
          end
        end
        MODE_BT: begin
          if (dollar_r && char_i == CH_LBRACE) begin
            // Consume the brace of a "${" opener.
            dollar_nxt = 1'b0;
            if (depth_r < DEPTH_MAX) depth_nxt = depth_r + DEPTH_W'(1);
          end else begin
            dollar_nxt = 1'b0;
            if (char_i == CH_DQUOTE || char_i == CH_SQUOTE) begin
              quote_nxt = (char_i == CH_SQUOTE);
              mode_nxt  = MODE_BTQ;
            end else if (char_i == CH_BACKTICK) begin
              if (depth_r == '0) begin
                tok0.kind    = KIND_INTERP;
                tok0.end_pos = pos_p1;
                n            = 2'd1;
                mode_nxt     = MODE_IDLE;
              end
            end else if (char_i == CH_DOLLAR) begin
              dollar_nxt = 1'b1;
            end else if (char_i == CH_RBRACE && depth_r != '0) begin
              depth_nxt = depth_r - DEPTH_W'(1);
            end
          end
        end
        MODE_LT, MODE_GT: begin
          mode_nxt = MODE_IDLE;
          n        = 2'd1;
          if (char_i == CH_EQUAL) begin
            tok0.kind    = (mode_r == MODE_LT) ? KIND_LTE : KIND_GTE;
            tok0.end_pos = pos_p1;
          end else begin
            tok0.kind = (mode_r == MODE_LT) ? KIND_LT : KIND_GT;
            do_start  = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          do_start = 1'b1;
        end
      endcase

      if (do_start && !si_space) begin
        tok_start_nxt = pos_r;
        mode_nxt      = si_mode;
        if (si_mode == MODE_BT) begin
          depth_nxt  = '0;
          dollar_nxt = 1'b0;
        end
        if (si_mode == MODE_STR) quote_nxt = si_quote;
        if (si_mode == MODE_WORD) begin
          prefix_nxt = {24'h000000, fold_b};
          len_nxt    = 3'd1;
        end
        if (si_emit) begin
          if (n == 2'd0) begin
            tok0 = '{kind: si_kind, start_pos: pos_r, end_pos: pos_p1, last: 1'b1};
          end else begin
            tok1 = '{kind: si_kind, start_pos: pos_r, end_pos: pos_p1, last: 1'b1};
          end
          n = n + 2'd1;
        end
      end
    end
    tok0.last = (n == 2'd1);
  end

  assign push_o = '{count: (step_en ? n : 2'd0), tok0: tok0, tok1: tok1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      quote_r     <= 1'b0;
      depth_r     <= '0;
      dollar_r    <= 1'b0;
      tok_start_r <= 16'd0;
      pos_r       <= 16'd0;
      prefix_r    <= 32'd0;
      len_r       <= 3'd0;
    end else if (step_en) begin
      mode_r      <= mode_nxt;
      quote_r     <= quote_nxt;
      depth_r     <= depth_nxt;
      dollar_r    <= dollar_nxt;
      tok_start_r <= tok_start_nxt;
      pos_r       <= pos_nxt;
      prefix_r    <= prefix_nxt;
      len_r       <= len_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= POS_CAP)
    else $error("position above cap");
  a_depth_cap: assert property (@(posedge clk) disable iff (!rst_n) depth_r <= DEPTH_MAX)
    else $error("interp depth above limit");
  a_dollar_bt: assert property (@(posedge clk) disable iff (!rst_n)
    dollar_r |-> mode_r == MODE_BT)
    else $error("dollar pending outside backtick literal");
  a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && eot_i) |=> (mode_r == MODE_IDLE && pos_r == 16'd0))
    else $error("lexer did not restart after end of text");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/qel_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qel_fifo
// Four-entry token queue: takes up to two tokens per cycle, gives one while out_ready_i is high.
// ----------------------------------------------------------------------------
module qel_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  qel_pkg::lex_push_t      push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output qel_pkg::token_t         head_o
);
  import qel_pkg::*;

  token_t     mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign out_valid_o = (count_r != 3'd0);
  assign room_o      = (count_r <= 3'd2);
  assign head_o      = mem_r[rd_ptr_r];
  assign pop         = out_valid_o && out_ready_i;

  assign wr_ptr_nxt = wr_ptr_r + push_i.count;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign count_nxt  = count_r + {1'b0, push_i.count} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push_i.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n) count_r <= 3'd4)
    else $error("token queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i.count != 2'd0) |-> count_r <= 3'd2)
    else $error("push without room");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_o && head_o.kind == KIND_END) |-> head_o.last)
    else $error("end token not marked last");
`endif

endmodule
`default_nettype wire
